### src/mpc_pkg.sv
// Shared types and constants for the PS/2 mouse packet cursor block.
// Used by every module in src; depends on nothing.
package mpc_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int DELTA_W = 9;
    localparam int COORD_W = 10;
    // Signed working width for cursor sums: 10-bit position plus 9-bit delta
    localparam int SUM_W   = COORD_W + 2;

    // Output tdata: 5 flag bits, two deltas, two coordinates, padded to bytes
    localparam int OUT_BITS = 5 + 2 * DELTA_W + 2 * COORD_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_X_LIMIT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_Y_LIMIT = 1'b1;

    // Reset values
    localparam logic [COORD_W-1:0] X_LIMIT_RESET = 10'd800;
    localparam logic [COORD_W-1:0] Y_LIMIT_RESET = 10'd600;
    localparam logic [COORD_W-1:0] CURSOR_RESET  = 10'd5;

    // Bit positions in the first byte of a packet
    localparam int SYNC_BIT   = 3;
    localparam int X_SIGN_BIT = 4;
    localparam int Y_SIGN_BIT = 5;
    localparam int X_OVF_BIT  = 6;
    localparam int Y_OVF_BIT  = 7;

    // Byte position within a packet
    typedef enum logic [1:0] {
        POS_FLAGS = 2'd0,
        POS_XMOVE = 2'd1,
        POS_YMOVE = 2'd2
    } pos_t;

    // Decoded packet, as queued between the front and back parts
    typedef struct packed {
        logic                      left_button;
        logic                      right_button;
        logic                      middle_button;
        logic                      x_overflow;
        logic                      y_overflow;
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
    } pkt_t;

    // Front to queue: push request
    typedef struct packed {
        logic valid;
        pkt_t pkt;
    } qpush_t;

    // Queue to back: head of queue
    typedef struct packed {
        logic valid;
        pkt_t pkt;
    } qhead_t;

endpackage

### src/mpc_front.sv
// Front part: accepts mouse bytes, finds the packet start and decodes
// each completed three-byte packet. Depends on mpc_pkg.
module mpc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [mpc_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] rx_byte
    input  logic                         queue_full,
    output mpc_pkg::qpush_t              push
);

    mpc_pkg::pos_t pos_reg;
    mpc_pkg::pos_t pos_next;
    logic [mpc_pkg::BYTE_W-1:0] flags_reg;
    logic [mpc_pkg::BYTE_W-1:0] flags_next;
    logic [mpc_pkg::BYTE_W-1:0] xmove_reg;
    logic [mpc_pkg::BYTE_W-1:0] xmove_next;
    logic accept;

    // Only the last byte of a packet needs room in the queue
    assign s_tready = (pos_reg != mpc_pkg::POS_YMOVE) || !queue_full;
    assign accept   = s_tvalid && s_tready;

    // Next byte position
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            unique case (pos_reg)
                mpc_pkg::POS_XMOVE: pos_next = mpc_pkg::POS_YMOVE;
                mpc_pkg::POS_YMOVE: pos_next = mpc_pkg::POS_FLAGS;
                default:
                begin
                    // waiting for sync: drop bytes without the sync bit
                    if (s_tdata[mpc_pkg::SYNC_BIT])
                        pos_next = mpc_pkg::POS_XMOVE;
                    else
                        pos_next = mpc_pkg::POS_FLAGS;
                end
            endcase
        end
    end

    // Byte capture and packet decode
    always_comb
    begin
        flags_next = flags_reg;
        xmove_next = xmove_reg;
        push       = '0;
        if (accept)
        begin
            unique case (pos_reg)
                mpc_pkg::POS_XMOVE: xmove_next = s_tdata;
                mpc_pkg::POS_YMOVE:
                begin
                    push.valid             = 1'b1;
                    push.pkt.left_button   = flags_reg[0];
                    push.pkt.right_button  = flags_reg[1];
                    push.pkt.middle_button = flags_reg[2];
                    push.pkt.x_overflow    = flags_reg[mpc_pkg::X_OVF_BIT];
                    push.pkt.y_overflow    = flags_reg[mpc_pkg::Y_OVF_BIT];
                    push.pkt.delta_x = {flags_reg[mpc_pkg::X_SIGN_BIT], xmove_reg};
                    push.pkt.delta_y = {flags_reg[mpc_pkg::Y_SIGN_BIT], s_tdata};
                end
                default:
                begin
                    if (s_tdata[mpc_pkg::SYNC_BIT])
                        flags_next = s_tdata;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= mpc_pkg::POS_FLAGS;
        else
            pos_reg <= pos_next;
    end

    // Payload bytes, no reset
    always_ff @(posedge clk)
    begin
        flags_reg <= flags_next;
        xmove_reg <= xmove_next;
    end

endmodule

### src/mpc_queue.sv
// Short queue of decoded packets between the front and back parts.
// Depends on mpc_pkg.
module mpc_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mpc_pkg::qpush_t push,
    output logic            full,
    input  logic            pop,
    output mpc_pkg::qhead_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    mpc_pkg::pkt_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.pkt   = slot_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && head.valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push.pkt;
    end

endmodule

### src/mpc_back.sv
// Back part: applies each decoded packet to the kept cursor, clamps it,
// and holds the result in the output register. Depends on mpc_pkg.
module mpc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mpc_pkg::qhead_t               head,
    output logic                          pop,
    input  logic [mpc_pkg::COORD_W-1:0]   x_limit,
    input  logic [mpc_pkg::COORD_W-1:0]   y_limit,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mpc_pkg::OUT_W-1:0]     m_tdata
);

    localparam int SUM_W   = mpc_pkg::SUM_W;
    localparam int COORD_W = mpc_pkg::COORD_W;
    localparam int DELTA_W = mpc_pkg::DELTA_W;

    logic [COORD_W-1:0] pos_x_reg;
    logic [COORD_W-1:0] pos_x_next;
    logic [COORD_W-1:0] pos_y_reg;
    logic [COORD_W-1:0] pos_y_next;
    logic               valid_reg;
    logic               valid_next;
    logic [mpc_pkg::OUT_W-1:0] data_reg;
    logic [mpc_pkg::OUT_W-1:0] data_next;
    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_y;
    logic [COORD_W-1:0]        clamp_x;
    logic [COORD_W-1:0]        clamp_y;

    assign pop      = head.valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    // Cursor sums: x adds delta_x, y subtracts delta_y
    assign sum_x = $signed({2'b00, pos_x_reg})
                 + {{(SUM_W - DELTA_W){head.pkt.delta_x[DELTA_W-1]}}, head.pkt.delta_x};
    assign sum_y = $signed({2'b00, pos_y_reg})
                 - {{(SUM_W - DELTA_W){head.pkt.delta_y[DELTA_W-1]}}, head.pkt.delta_y};

    // Clamp to 0..limit
    always_comb
    begin
        priority if (sum_x[SUM_W-1])
            clamp_x = '0;
        else if (sum_x[SUM_W-2:0] > {1'b0, x_limit})
            clamp_x = x_limit;
        else
            clamp_x = sum_x[COORD_W-1:0];

        priority if (sum_y[SUM_W-1])
            clamp_y = '0;
        else if (sum_y[SUM_W-2:0] > {1'b0, y_limit})
            clamp_y = y_limit;
        else
            clamp_y = sum_y[COORD_W-1:0];
    end

    // Cursor and output register update
    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (pop)
        begin
            // overflowed axis keeps its position
            if (!head.pkt.x_overflow)
                pos_x_next = clamp_x;
            if (!head.pkt.y_overflow)
                pos_y_next = clamp_y;
            valid_next = 1'b1;
            data_next  = mpc_pkg::OUT_W'({pos_y_next, pos_x_next,
                                          head.pkt.delta_y, head.pkt.delta_x,
                                          head.pkt.y_overflow, head.pkt.x_overflow,
                                          head.pkt.middle_button,
                                          head.pkt.right_button,
                                          head.pkt.left_button});
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= mpc_pkg::CURSOR_RESET;
            pos_y_reg <= mpc_pkg::CURSOR_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

### src/ps2_mouse_packet_cursor.sv
// After the third byte of a packet is accepted, the packet waits at the head of the queue and
// loads the output register, raising m_tvalid, once it is empty or its result is being taken.
// Input takes one byte per cycle but stalls the last byte of a packet while the queue is full;
// the queue and the output register let the byte side run on while a result waits to be taken.
// Reset (rst_n, async, low): cursor at (5,5), limits 800 and 600, waiting for a packet start.
// Depends on mpc_pkg, mpc_front, mpc_queue, mpc_back.
module ps2_mouse_packet_cursor #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mpc_pkg::BYTE_W-1:0]          s_tdata,   // [7:0] rx_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] left_button, [1] right_button, [2] middle_button, [3] x_overflow,
    // [4] y_overflow, [13:5] delta_x, [22:14] delta_y, [32:23] cursor_x,
    // [42:33] cursor_y, [47:43] zero
    output logic [mpc_pkg::OUT_W-1:0]           m_tdata,
    input  logic                                cfg_we,
    input  logic [mpc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [mpc_pkg::COORD_W-1:0]         cfg_data
);

    logic [mpc_pkg::COORD_W-1:0] x_limit_reg;
    logic [mpc_pkg::COORD_W-1:0] x_limit_next;
    logic [mpc_pkg::COORD_W-1:0] y_limit_reg;
    logic [mpc_pkg::COORD_W-1:0] y_limit_next;
    mpc_pkg::qpush_t push;
    mpc_pkg::qhead_t head;
    logic            queue_full;
    logic            pop;

    // Limit register writes
    always_comb
    begin
        x_limit_next = x_limit_reg;
        y_limit_next = y_limit_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                mpc_pkg::CFG_X_LIMIT: x_limit_next = cfg_data;
                mpc_pkg::CFG_Y_LIMIT: y_limit_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= mpc_pkg::X_LIMIT_RESET;
            y_limit_reg <= mpc_pkg::Y_LIMIT_RESET;
        end
        else
        begin
            x_limit_reg <= x_limit_next;
            y_limit_reg <= y_limit_next;
        end
    end

    mpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push       (push)
    );

    mpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .pop   (pop),
        .head  (head)
    );

    mpc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .x_limit  (x_limit_reg),
        .y_limit  (y_limit_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### src/mpc_checker.sv
// Port-level checker for ps2_mouse_packet_cursor, bound to the top level.
// Depends on mpc_pkg.
module mpc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mpc_pkg::OUT_W-1:0]         m_tdata
);

    logic                        seen_reg;
    logic [mpc_pkg::COORD_W-1:0] last_x_reg;
    logic [mpc_pkg::COORD_W-1:0] last_y_reg;
    logic                        out_accept;

    assign out_accept = m_tvalid && m_tready;

    // Track the cursor of the last delivered item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg   <= 1'b0;
            last_x_reg <= mpc_pkg::CURSOR_RESET;
            last_y_reg <= mpc_pkg::CURSOR_RESET;
        end
        else if (out_accept)
        begin
            seen_reg   <= 1'b1;
            last_x_reg <= m_tdata[32:23];
            last_y_reg <= m_tdata[42:33];
        end
    end

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Overflowed x axis keeps the cursor
    assert property (@(posedge clk) disable iff (!rst_n)
        out_accept && m_tdata[3] |-> m_tdata[32:23] == last_x_reg)
        else $error("cursor_x moved on x overflow");

    // Overflowed y axis keeps the cursor
    assert property (@(posedge clk) disable iff (!rst_n)
        out_accept && m_tdata[4] |-> m_tdata[42:33] == last_y_reg)
        else $error("cursor_y moved on y overflow");

    // Pad bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[mpc_pkg::OUT_W-1:mpc_pkg::OUT_BITS] == '0)
        else $error("tdata pad bits set");

    // seen_reg only qualifies tracking; first item has nothing to compare beyond reset
    assert property (@(posedge clk) disable iff (!rst_n)
        !seen_reg && out_accept && m_tdata[3] |-> m_tdata[32:23] == mpc_pkg::CURSOR_RESET)
        else $error("first result moved x on overflow");

endmodule

bind ps2_mouse_packet_cursor mpc_checker u_mpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### bench/testbench.sv
// Self-checking bench for ps2_mouse_packet_cursor: feeds mouse bytes, predicts the decoded
// packet and clamped cursor for each completed packet, and compares every output item.
// Depends on mpc_pkg and the ps2_mouse_packet_cursor RTL in src.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // One decoded packet with the cursor after it
    typedef struct {
        logic                               left_button;
        logic                               right_button;
        logic                               middle_button;
        logic                               x_overflow;
        logic                               y_overflow;
        logic signed [mpc_pkg::DELTA_W-1:0] delta_x;
        logic signed [mpc_pkg::DELTA_W-1:0] delta_y;
        logic [mpc_pkg::COORD_W-1:0]        cursor_x;
        logic [mpc_pkg::COORD_W-1:0]        cursor_y;
    } cursor_report_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [mpc_pkg::BYTE_W-1:0]     s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [mpc_pkg::OUT_W-1:0]      m_tdata;
    logic                           cfg_we = 1'b0;
    logic [mpc_pkg::CFG_ADDR_W-1:0] cfg_addr = mpc_pkg::CFG_X_LIMIT;
    logic [mpc_pkg::COORD_W-1:0]    cfg_data = '0;

    // Predicted decoder state
    mpc_pkg::pos_t               next_pos = mpc_pkg::POS_FLAGS;
    logic [mpc_pkg::BYTE_W-1:0]  held_flags = '0;
    logic [mpc_pkg::BYTE_W-1:0]  held_xmove = '0;
    logic [mpc_pkg::COORD_W-1:0] cur_x = mpc_pkg::CURSOR_RESET;
    logic [mpc_pkg::COORD_W-1:0] cur_y = mpc_pkg::CURSOR_RESET;
    logic [mpc_pkg::COORD_W-1:0] lim_x = mpc_pkg::X_LIMIT_RESET;
    logic [mpc_pkg::COORD_W-1:0] lim_y = mpc_pkg::Y_LIMIT_RESET;

    cursor_report_t cursor_reports[$];
    int             mismatch_count = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             ready_hold = 0;

    ps2_mouse_packet_cursor u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [mpc_pkg::COORD_W-1:0] clamp_coord(
        int v, logic [mpc_pkg::COORD_W-1:0] lim);
        if (v < 0)
            return '0;
        if (v > int'(lim))
            return lim;
        return v[mpc_pkg::COORD_W-1:0];
    endfunction

    // Advance the predicted decoder by one accepted byte
    task automatic decode_mouse_byte(input logic [mpc_pkg::BYTE_W-1:0] b);
        cursor_report_t rep;
        case (next_pos)
            mpc_pkg::POS_XMOVE:
            begin
                held_xmove = b;
                next_pos   = mpc_pkg::POS_YMOVE;
            end
            mpc_pkg::POS_YMOVE:
            begin
                rep.left_button   = held_flags[0];
                rep.right_button  = held_flags[1];
                rep.middle_button = held_flags[2];
                rep.x_overflow    = held_flags[mpc_pkg::X_OVF_BIT];
                rep.y_overflow    = held_flags[mpc_pkg::Y_OVF_BIT];
                rep.delta_x       = {held_flags[mpc_pkg::X_SIGN_BIT], held_xmove};
                rep.delta_y       = {held_flags[mpc_pkg::Y_SIGN_BIT], b};
                // an axis with its overflow flag set keeps its position
                if (!rep.x_overflow)
                    cur_x = clamp_coord(int'(cur_x) + int'(rep.delta_x), lim_x);
                if (!rep.y_overflow)
                    cur_y = clamp_coord(int'(cur_y) - int'(rep.delta_y), lim_y);
                rep.cursor_x = cur_x;
                rep.cursor_y = cur_y;
                cursor_reports.push_back(rep);
                next_pos = mpc_pkg::POS_FLAGS;
            end
            default:
            begin
                // bytes without the sync bit are dropped while waiting for a start
                if (b[mpc_pkg::SYNC_BIT])
                begin
                    held_flags = b;
                    next_pos   = mpc_pkg::POS_XMOVE;
                end
            end
        endcase
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_report(input logic [mpc_pkg::OUT_W-1:0] d);
        cursor_report_t rep;
        if (cursor_reports.size() == 0)
        begin
            $error("unexpected output item: %h", d);
            mismatch_count++;
        end
        else
        begin
            rep = cursor_reports.pop_front();
            compare_field("left_button", int'(rep.left_button), int'(d[0]));
            compare_field("right_button", int'(rep.right_button), int'(d[1]));
            compare_field("middle_button", int'(rep.middle_button), int'(d[2]));
            compare_field("x_overflow", int'(rep.x_overflow), int'(d[3]));
            compare_field("y_overflow", int'(rep.y_overflow), int'(d[4]));
            compare_field("delta_x", int'(rep.delta_x), int'($signed(d[13:5])));
            compare_field("delta_y", int'(rep.delta_y), int'($signed(d[22:14])));
            compare_field("cursor_x", int'(rep.cursor_x), int'(d[32:23]));
            compare_field("cursor_y", int'(rep.cursor_y), int'(d[42:33]));
        end
    endtask

    // Observe handshakes and register writes at each rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_report(m_tdata);
            if (cfg_we)
            begin
                if (cfg_addr == mpc_pkg::CFG_X_LIMIT)
                    lim_x = cfg_data;
                else if (cfg_addr == mpc_pkg::CFG_Y_LIMIT)
                    lim_y = cfg_data;
            end
            if (s_tvalid && s_tready)
                decode_mouse_byte(s_tdata);
        end
    end

    // Output side: random stalls, or a counted hold-off
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            m_tready <= 1'b0;
            ready_hold = ready_hold - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one byte and wait until it is taken
    task automatic send_byte(input logic [mpc_pkg::BYTE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_packet(input logic [mpc_pkg::BYTE_W-1:0] flags,
                               input logic [mpc_pkg::BYTE_W-1:0] xb,
                               input logic [mpc_pkg::BYTE_W-1:0] yb);
        send_byte(flags);
        send_byte(xb);
        send_byte(yb);
    endtask

    task automatic send_random_packet();
        send_packet(mpc_pkg::BYTE_W'($urandom_range(255) | (1 << mpc_pkg::SYNC_BIT)),
                    mpc_pkg::BYTE_W'($urandom_range(255)),
                    mpc_pkg::BYTE_W'($urandom_range(255)));
    endtask

    // Stop sending and wait until every predicted packet has come out
    task automatic wait_reports_done();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (cursor_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [mpc_pkg::CFG_ADDR_W-1:0] idx,
                               input logic [mpc_pkg::COORD_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [mpc_pkg::COORD_W-1:0] pick_limit();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return mpc_pkg::COORD_W'($urandom_range(1023));
        endcase
    endfunction

    // Bytes without the sync bit before any packet, and between packets
    task automatic test_unsynced_bytes();
        send_byte(8'h00);
        send_byte(8'hF7);
        send_packet(8'h08, 8'h00, 8'h00);
        send_byte(8'h77);
        wait_reports_done();
    endtask

    // Largest and smallest deltas, every button and both overflow flags
    task automatic test_field_extremes();
        send_packet(8'h08, 8'hFF, 8'h00);
        send_packet(8'h38, 8'h00, 8'h00);
        send_packet(8'h0F, 8'h80, 8'h7F);
        send_packet(8'hCF, 8'hFF, 8'hFF);
        send_packet(8'h4B, 8'h12, 8'h34);
        send_packet(8'hBC, 8'hF7, 8'h08);
        wait_reports_done();
    endtask

    // Clamping at both limit extremes, and a limit lowered below the cursor
    task automatic test_limit_clamping();
        write_limit(mpc_pkg::CFG_X_LIMIT, 10'd1023);
        write_limit(mpc_pkg::CFG_Y_LIMIT, 10'd1023);
        repeat (5) send_packet(8'h28, 8'hFF, 8'h00);
        wait_reports_done();
        write_limit(mpc_pkg::CFG_X_LIMIT, 10'd100);
        write_limit(mpc_pkg::CFG_Y_LIMIT, 10'd200);
        send_packet(8'h28, 8'h01, 8'hFF);
        send_packet(8'h18, 8'hF0, 8'h20);
        wait_reports_done();
        write_limit(mpc_pkg::CFG_X_LIMIT, 10'd0);
        write_limit(mpc_pkg::CFG_Y_LIMIT, 10'd0);
        send_packet(8'h08, 8'h7F, 8'h00);
        send_packet(8'h38, 8'h80, 8'h80);
        wait_reports_done();
    endtask

    // Output held off long enough for the block to fill up and stall its input
    task automatic test_output_holdoff();
        write_limit(mpc_pkg::CFG_X_LIMIT, mpc_pkg::X_LIMIT_RESET);
        write_limit(mpc_pkg::CFG_Y_LIMIT, mpc_pkg::Y_LIMIT_RESET);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        ready_hold     = 300;
        repeat (30) send_random_packet();
        wait_reports_done();
    endtask

    // Mostly well-formed packets with random content, plus dropped and stray bytes
    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int items);
        int sent;
        int pick;
        sent = 0;
        write_limit(mpc_pkg::CFG_X_LIMIT, pick_limit());
        write_limit(mpc_pkg::CFG_Y_LIMIT, pick_limit());
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < items)
        begin
            pick = $urandom_range(99);
            if (pick < 85)
            begin
                send_random_packet();
                sent += 3;
            end
            else if (pick < 93)
            begin
                send_byte(mpc_pkg::BYTE_W'($urandom_range(255) & ~(1 << mpc_pkg::SYNC_BIT)));
                sent++;
            end
            else
            begin
                send_byte(mpc_pkg::BYTE_W'($urandom_range(255)));
                sent++;
            end
        end
        wait_reports_done();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_unsynced_bytes();
        test_field_extremes();
        test_limit_clamping();
        test_output_holdoff();
        test_random_phase(0, 0, 400);
        test_random_phase(57, 0, 400);
        test_random_phase(0, 57, 400);
        test_random_phase(30, 30, 400);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### ps2_mouse_packet_cursor.f
src/mpc_pkg.sv
src/mpc_front.sv
src/mpc_queue.sv
src/mpc_back.sv
src/ps2_mouse_packet_cursor.sv
src/mpc_checker.sv
bench/testbench.sv
